/* hw/rtl/gms_pkg.sv */
// Shared types, constants and fixed-point helpers for the grid metric stencil.
// No dependencies; used by gms_recip and grid_metric_stencil_top.
package gms_pkg;

  localparam int CW         = 32;   // coordinate width
  localparam int FB         = 16;   // fraction bits
  localparam int DIV_STAGES = 32;   // one quotient bit per stage
  localparam int REM_W      = 3 * FB + 1;

  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  // configuration register indexes
  localparam logic REG_MOVING_MESH = 1'b0;
  localparam logic REG_INV_DT      = 1'b1;

  typedef struct packed {
    logic en;    // pipeline advance
    logic vld;   // transaction entering
  } div_ctl_t;

  typedef struct packed {
    logic signed [CW-1:0] x_xi;
    logic signed [CW-1:0] y_xi;
    logic signed [CW-1:0] x_eta;
    logic signed [CW-1:0] y_eta;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic                 neg;
    logic                 sing;
    logic                 small_det;
  } side_t;

  // saturate a 66-bit signed value to CW bits
  function automatic logic [CW-1:0] sat_cw(input logic signed [65:0] v);
    logic hi_ok;
    hi_ok = (v[65:CW-1] == '0) || (v[65:CW-1] == '1);
    if (hi_ok) return v[CW-1:0];
    return v[65] ? SMIN : SMAX;
  endfunction

  // saturate a 66-bit signed value to 64 bits
  function automatic logic [63:0] sat_64(input logic signed [65:0] v);
    if ((v[65:63] == 3'b000) || (v[65:63] == 3'b111)) return v[63:0];
    return v[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  // floor shift by FB then saturate
  function automatic logic [CW-1:0] shr_sat(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> FB;
    return sat_cw(s);
  endfunction

endpackage

/* hw/rtl/gms_recip.sv */
// Pipelined restoring divider: 2^(3*FB) / d, one quotient bit per stage.
// Depends on gms_pkg. Quotient is valid only when d > 2^FB.
module gms_recip (
  input  logic                              clk,
  input  logic                              rst,
  input  gms_pkg::div_ctl_t                 ctl,
  input  logic [63:0]                       d,
  output logic                              q_vld,
  output logic [gms_pkg::DIV_STAGES-1:0]    q
);

  localparam int NS = gms_pkg::DIV_STAGES;
  localparam int RW = gms_pkg::REM_W;

  logic [RW-1:0] rem [0:NS-1];
  logic [63:0]   dq  [0:NS-1];
  logic [NS-1:0] qq  [0:NS-1];
  logic [NS-1:0] vld;

  for (genvar r = 0; r < NS; r++) begin : g_rank
    localparam int B = NS - 1 - r;
    logic [RW-1:0]    rem_in;
    logic [63:0]      d_in;
    logic [NS-1:0]    q_in;
    logic             v_in;
    logic [63+NS:0]   trial;
    logic [63+NS:0]   rem_ext;
    logic             take;

    if (r == 0) begin : g_first
      assign rem_in = {1'b1, {(RW-1){1'b0}}};
      assign d_in   = d;
      assign q_in   = '0;
      assign v_in   = ctl.vld;
    end else begin : g_next
      assign rem_in = rem[r-1];
      assign d_in   = dq[r-1];
      assign q_in   = qq[r-1];
      assign v_in   = vld[r-1];
    end

    assign trial   = {{NS{1'b0}}, d_in} << B;
    assign rem_ext = {{(64+NS-RW){1'b0}}, rem_in};
    assign take    = (rem_ext >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[r] <= 1'b0;
      end else if (ctl.en) begin
        vld[r] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[r] <= take ? rem_in - trial[RW-1:0] : rem_in;
        dq[r]  <= d_in;
        qq[r]  <= q_in | (take ? (NS'(1) << B) : '0);
      end
    end
  end

  assign q_vld = vld[NS-1];
  assign q     = qq[NS-1];

endmodule

/* hw/rtl/grid_metric_stencil_top.sv */
// Grid metric stencil: central differences, Jacobian, inverse and time metrics.
// Depends on gms_pkg and gms_recip.
//
// Input channel in_valid/in_ready carries one four-point stencil plus the
// current and previous center position; output channel out_valid/out_ready
// carries J, the four inverse metrics, grid velocity and time metrics, and the
// singular flag. All values are signed Q16.16.
// The pipeline has 41 register stages: four front stages (differences,
// products, determinant, magnitude), 32 divider stages (one quotient bit
// each), and five back stages (J, metric products, metrics, time products,
// time metrics into the output register).
// Throughput is one transaction per cycle while the receiver does not stall.
// The whole pipeline advances while the output register is empty or being
// taken; when the receiver stalls with a result held, every stage holds and
// in_ready drops, so nothing is lost. Reset clears all valid bits and sets
// moving_mesh = 0, inv_time_step = 1.0. The user must write configuration
// (cfg_we/cfg_index/cfg_wdata) only while idle; the block does not enforce it.
module grid_metric_stencil_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] xi_fwd_x,
  input  logic signed [31:0] xi_fwd_y,
  input  logic signed [31:0] xi_back_x,
  input  logic signed [31:0] xi_back_y,
  input  logic signed [31:0] eta_fwd_x,
  input  logic signed [31:0] eta_fwd_y,
  input  logic signed [31:0] eta_back_x,
  input  logic signed [31:0] eta_back_y,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] prev_x,
  input  logic signed [31:0] prev_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] inv_det,
  output logic signed [31:0] xi_dx,
  output logic signed [31:0] xi_dy,
  output logic signed [31:0] eta_dx,
  output logic signed [31:0] eta_dy,
  output logic signed [31:0] grid_vel_x,
  output logic signed [31:0] grid_vel_y,
  output logic signed [31:0] xi_dt,
  output logic signed [31:0] eta_dt,
  output logic               singular
);

  localparam int NS = gms_pkg::DIV_STAGES;

  logic        moving_mesh;
  logic [30:0] inv_time_step;
  logic        adv;
  logic        v1, v2, v3, v4, v5, v6, v7, v8, v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      moving_mesh   <= 1'b0;
      inv_time_step <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        gms_pkg::REG_MOVING_MESH: moving_mesh   <= cfg_wdata[0];
        gms_pkg::REG_INV_DT:      inv_time_step <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // valid chain (divider carries its own in between)
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8; out_valid <= v9;
    end
  end

  // stage 1: half differences and position differences
  logic signed [32:0] dax, day, dbx, dby;
  logic signed [31:0] s1_x_xi, s1_y_xi, s1_x_eta, s1_y_eta;
  logic signed [32:0] s1_dvx, s1_dvy;
  assign dax = 33'(xi_fwd_x) - 33'(xi_back_x);
  assign day = 33'(xi_fwd_y) - 33'(xi_back_y);
  assign dbx = 33'(eta_fwd_x) - 33'(eta_back_x);
  assign dby = 33'(eta_fwd_y) - 33'(eta_back_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_xi  <= dax[32:1];
      s1_y_xi  <= day[32:1];
      s1_x_eta <= dbx[32:1];
      s1_y_eta <= dby[32:1];
      s1_dvx   <= 33'(point_x) - 33'(prev_x);
      s1_dvy   <= 33'(point_y) - 33'(prev_y);
    end
  end

  // stage 2: determinant and velocity products
  logic signed [63:0] s2_pa, s2_pb;
  logic signed [64:0] s2_pvx, s2_pvy;
  logic signed [31:0] s2_x_xi, s2_y_xi, s2_x_eta, s2_y_eta;
  logic signed [31:0] rdt;
  assign rdt = $signed({1'b0, inv_time_step});

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pa    <= s1_x_xi * s1_y_eta;
      s2_pb    <= s1_x_eta * s1_y_xi;
      s2_pvx   <= s1_dvx * rdt;
      s2_pvy   <= s1_dvy * rdt;
      s2_x_xi  <= s1_x_xi;
      s2_y_xi  <= s1_y_xi;
      s2_x_eta <= s1_x_eta;
      s2_y_eta <= s1_y_eta;
    end
  end

  // stage 3: determinant, saturated velocity
  logic signed [63:0] s3_det;
  logic signed [31:0] s3_vx, s3_vy;
  logic signed [31:0] s3_x_xi, s3_y_xi, s3_x_eta, s3_y_eta;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_det   <= gms_pkg::sat_64(66'(s2_pa) - 66'(s2_pb));
      s3_vx    <= gms_pkg::shr_sat(66'(s2_pvx));
      s3_vy    <= gms_pkg::shr_sat(66'(s2_pvy));
      s3_x_xi  <= s2_x_xi;
      s3_y_xi  <= s2_y_xi;
      s3_x_eta <= s2_x_eta;
      s3_y_eta <= s2_y_eta;
    end
  end

  // stage 4: magnitude and classification
  logic [63:0]    s4_mag, mag;
  gms_pkg::side_t s4_side;
  assign mag = s3_det[63] ? (64'd0 - s3_det) : s3_det;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mag              <= mag;
      s4_side.x_xi        <= s3_x_xi;
      s4_side.y_xi        <= s3_y_xi;
      s4_side.x_eta       <= s3_x_eta;
      s4_side.y_eta       <= s3_y_eta;
      s4_side.vx          <= s3_vx;
      s4_side.vy          <= s3_vy;
      s4_side.neg         <= s3_det[63];
      s4_side.sing        <= (s3_det == 64'd0);
      // quotient would not fit 32 bits
      s4_side.small_det   <= (mag <= (64'd1 << gms_pkg::FB));
    end
  end

  // reciprocal pipeline with matching sideband delay
  gms_pkg::div_ctl_t dctl;
  logic [NS-1:0]     quo;
  gms_pkg::side_t    side_q [0:NS-1];
  assign dctl.en  = adv;
  assign dctl.vld = v4;

  gms_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .ctl   (dctl),
    .d     (s4_mag),
    .q_vld (v5),
    .q     (quo)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= s4_side;
      for (int i = 1; i < NS; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stage 5: saturated J
  gms_pkg::side_t     sd;
  logic signed [31:0] jac, s5_jac;
  gms_pkg::side_t     s5_side;
  assign sd = side_q[NS-1];

  always_comb begin
    if (sd.small_det) begin
      jac = sd.neg ? gms_pkg::SMIN : gms_pkg::SMAX;
    end else if (!sd.neg) begin
      jac = quo[31] ? gms_pkg::SMAX : quo;
    end else begin
      jac = (quo > gms_pkg::SMIN) ? gms_pkg::SMIN : (32'd0 - quo);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_jac  <= jac;
      s5_side <= sd;
    end
  end

  // stage 6: metric products
  logic signed [63:0] s6_m0, s6_m1, s6_m2, s6_m3;
  logic signed [31:0] s6_jac, s6_vx, s6_vy;
  logic               s6_sing;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_m0   <= s5_side.y_eta * s5_jac;
      s6_m1   <= s5_side.x_eta * s5_jac;
      s6_m2   <= s5_side.y_xi * s5_jac;
      s6_m3   <= s5_side.x_xi * s5_jac;
      s6_jac  <= s5_jac;
      s6_vx   <= s5_side.vx;
      s6_vy   <= s5_side.vy;
      s6_sing <= s5_side.sing;
    end
  end

  // stage 7: metrics
  logic signed [31:0] s7_xix, s7_xiy, s7_etax, s7_etay, s7_jac, s7_vx, s7_vy;
  logic               s7_sing;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_xix  <= gms_pkg::shr_sat(66'(s6_m0));
      s7_xiy  <= gms_pkg::shr_sat(66'sd0 - 66'(s6_m1));
      s7_etax <= gms_pkg::shr_sat(66'sd0 - 66'(s6_m2));
      s7_etay <= gms_pkg::shr_sat(66'(s6_m3));
      s7_jac  <= s6_jac;
      s7_vx   <= s6_vx;
      s7_vy   <= s6_vy;
      s7_sing <= s6_sing;
    end
  end

  // stage 8: time metric products
  logic signed [63:0] s8_t0, s8_t1, s8_t2, s8_t3;
  logic signed [31:0] s8_xix, s8_xiy, s8_etax, s8_etay, s8_jac, s8_vx, s8_vy;
  logic               s8_sing;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_t0   <= s7_vx * s7_xix;
      s8_t1   <= s7_vy * s7_xiy;
      s8_t2   <= s7_vx * s7_etax;
      s8_t3   <= s7_vy * s7_etay;
      s8_xix  <= s7_xix;
      s8_xiy  <= s7_xiy;
      s8_etax <= s7_etax;
      s8_etay <= s7_etay;
      s8_jac  <= s7_jac;
      s8_vx   <= s7_vx;
      s8_vy   <= s7_vy;
      s8_sing <= s7_sing;
    end
  end

  // stage 9: output register
  always_ff @(posedge clk) begin
    if (adv) begin
      inv_det    <= s8_jac;
      xi_dx      <= s8_xix;
      xi_dy      <= s8_xiy;
      eta_dx     <= s8_etax;
      eta_dy     <= s8_etay;
      singular   <= s8_sing;
      grid_vel_x <= moving_mesh ? s8_vx : 32'sd0;
      grid_vel_y <= moving_mesh ? s8_vy : 32'sd0;
      xi_dt      <= moving_mesh ?
                    gms_pkg::shr_sat(66'sd0 - 66'(s8_t0) - 66'(s8_t1)) : 32'sd0;
      eta_dt     <= moving_mesh ?
                    gms_pkg::shr_sat(66'sd0 - 66'(s8_t2) - 66'(s8_t3)) : 32'sd0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inv_det == gms_pkg::SMAX)
    else $error("singular result without saturated J");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !moving_mesh |-> grid_vel_x == 0 && grid_vel_y == 0 &&
                                  xi_dt == 0 && eta_dt == 0)
    else $error("static mesh result with nonzero time terms");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inv_det) && $stable(xi_dt) &&
                                $stable(singular))
    else $error("held result changed");

  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v5) && $stable(v8))
    else $error("pipeline moved during stall");

endmodule
